// ----- rtl/line_sensor_pid_steering_macros.svh -----
// Assertion macros shared by the line sensor steering checker.
`ifndef LINE_SENSOR_PID_STEERING_MACROS_SVH
`define LINE_SENSOR_PID_STEERING_MACROS_SVH

// Implication within the same cycle, masked while reset is held.
`define LSPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_sensor_pid_steering: check failed");

// Implication into the following cycle, masked while reset is held.
`define LSPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_sensor_pid_steering: check failed");

`endif

// ----- rtl/lsps_pkg.sv -----
`default_nettype none
// Shared constants, types and the centroid error table of the steering block.
package lsps_pkg;

  localparam int WINDOW_LEN_DEF = 30;
  localparam int ADC_BITS_DEF   = 12;

  localparam int SENSORS    = 5;
  localparam int ERR_W      = 13;
  localparam int INTEG_W    = 16;
  localparam int DIFF_W     = 14;
  localparam int GAIN_W     = 16;
  localparam int DIGIT_W    = 4;
  localparam int DIGITS     = GAIN_W / DIGIT_W;
  localparam int ACC_W      = 34;
  localparam int CORR_W     = 24;
  localparam int DUTY_W     = 15;
  localparam int HITS_W     = 5;
  localparam int THR_W      = 10;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int MAP_SPAN   = 1200;
  localparam int MAP_TOP    = 1000;
  localparam int MASKS      = 1 << SENSORS;

  localparam logic signed [ERR_W-1:0] LOST_ERROR = 13'sd2560;

  localparam int WEIGHT [SENSORS] = '{-5, -3, 1, 3, 5};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 4'd0,
    CFG_GAIN_I    = 4'd1,
    CFG_GAIN_D    = 4'd2,
    CFG_THRESHOLD = 4'd3,
    CFG_INT_LIMIT = 4'd4,
    CFG_BASE_DUTY = 4'd5,
    CFG_MIN_DUTY  = 4'd6,
    CFG_MAX_DUTY  = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_CORR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

  function automatic logic [ERR_W*MASKS-1:0] build_err_tab();
    logic [ERR_W*MASKS-1:0] tab;
    int wsum;
    int n;
    int q;
    int m;
    int s;
    tab = '0;
    for (m = 0; m < MASKS; m++) begin
      wsum = 0;
      n    = 0;
      for (s = 0; s < SENSORS; s++) begin
        if (m[s]) begin
          wsum = wsum + WEIGHT[s];
          n    = n + 1;
        end
      end
      case (n)
        1:       q = wsum * 256;
        2:       q = (wsum * 256) / 2;
        3:       q = (wsum * 256) / 3;
        4:       q = (wsum * 256) / 4;
        5:       q = (wsum * 256) / 5;
        default: q = 0;
      endcase
      tab[m*ERR_W +: ERR_W] = ERR_W'(q);
    end
    return tab;
  endfunction

  localparam logic [ERR_W*MASKS-1:0] ERR_TAB = build_err_tab();

  function automatic logic signed [ERR_W-1:0] centroid_err(input logic [SENSORS-1:0] mask);
    return $signed(ERR_TAB[int'(mask) * ERR_W +: ERR_W]);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lsps_mac.sv -----
`default_nettype none
// Digit-serial multiply-accumulate unit for the three PID products.
module lsps_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [lsps_pkg::GAIN_W-1:0]         gain_p,
  input  logic [lsps_pkg::GAIN_W-1:0]         gain_i,
  input  logic [lsps_pkg::GAIN_W-1:0]         gain_d,
  input  logic signed [lsps_pkg::ERR_W-1:0]   err,
  input  logic signed [lsps_pkg::INTEG_W-1:0] integ,
  input  logic signed [lsps_pkg::DIFF_W-1:0]  diff,
  output logic signed [lsps_pkg::ACC_W-1:0]   acc,
  output lsps_pkg::mac_stat_t                 stat
);
  import lsps_pkg::*;

  localparam int CNT_W = $clog2(DIGITS);

  logic [GAIN_W-1:0]        gp_r, gi_r, gd_r;
  logic signed [ACC_W-1:0]  mp_r, mi_r, md_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  term_p, term_i, term_d;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  assign term_p  = $signed({1'b0, gp_r[DIGIT_W-1:0]}) * mp_r;
  assign term_i  = $signed({1'b0, gi_r[DIGIT_W-1:0]}) * mi_r;
  assign term_d  = $signed({1'b0, gd_r[DIGIT_W-1:0]}) * md_r;
  assign acc_nxt = acc_r + term_p + term_i + term_d;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gp_r  <= gain_p;
      gi_r  <= gain_i;
      gd_r  <= gain_d;
      mp_r  <= ACC_W'(err);
      mi_r  <= ACC_W'(integ);
      md_r  <= ACC_W'(diff);
      acc_r <= '0;
    end else if (busy_r) begin
      gp_r  <= gp_r >> DIGIT_W;
      gi_r  <= gi_r >> DIGIT_W;
      gd_r  <= gd_r >> DIGIT_W;
      mp_r  <= mp_r <<< DIGIT_W;
      mi_r  <= mi_r <<< DIGIT_W;
      md_r  <= md_r <<< DIGIT_W;
      acc_r <= acc_nxt;
    end
  end

  assign acc       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ----- rtl/line_sensor_pid_steering.sv -----
`default_nettype none
// Top level of the line sensor PID steering block.
//
// Usage: a request on the input channel carries five raw sensor samples. It is
// taken at a rising edge with in_valid high and in_stall low. The block holds
// in_stall high while it works on one request, so requests are handled one at
// a time. The result leaves on the output channel and is taken at an edge with
// out_valid high and out_stall low. Registers are written on the cfg_ channel,
// which is always ready; they should be changed only while the block is idle.
// The PID products are formed four gain bits a cycle in a shared digit-serial
// unit; a request passes in order through the set-up, multiply, rounding and
// duty clamp steps before its result is loaded into the output register.
// If the receiver stalls, the finished result waits in the output register;
// one further request may be taken and worked on meanwhile, and it waits in
// the last step until the output register is free.
// Reset (rst_n low, synchronous) clears all history, the edge hit windows and
// both channels, and returns every register to its reset value.
module line_sensor_pid_steering #(
  parameter int WINDOW_LEN = lsps_pkg::WINDOW_LEN_DEF,
  parameter int ADC_BITS   = lsps_pkg::ADC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ADC_BITS-1:0]                 in_sample_far_left,
  input  logic [ADC_BITS-1:0]                 in_sample_left,
  input  logic [ADC_BITS-1:0]                 in_sample_center,
  input  logic [ADC_BITS-1:0]                 in_sample_right,
  input  logic [ADC_BITS-1:0]                 in_sample_far_right,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lsps_pkg::ERR_W-1:0]   out_position_error,
  output logic signed [lsps_pkg::CORR_W-1:0]  out_steer_correction,
  output logic [lsps_pkg::DUTY_W-1:0]         out_left_duty_out,
  output logic [lsps_pkg::DUTY_W-1:0]         out_right_duty_out,
  output logic                                out_left_branch,
  output logic                                out_right_branch,
  output logic                                out_line_lost,
  output logic [lsps_pkg::HITS_W-1:0]         out_left_hits,
  output logic [lsps_pkg::HITS_W-1:0]         out_right_hits,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lsps_pkg::*;

  localparam int ADC_MAX   = (1 << ADC_BITS) - 1;
  localparam int PROD_W    = ADC_BITS + 11;
  localparam int CNT_BITS  = $clog2(WINDOW_LEN + 1);
  localparam int HIT_CNT_W = (CNT_BITS > HITS_W) ? CNT_BITS : HITS_W;
  localparam int SUM_W     = INTEG_W + 1;
  localparam int DSUM_W    = CORR_W + 2;
  localparam int CFULL_W   = ACC_W - 8;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [THR_W-1:0]  thr_r;
  logic [PCT_W-1:0]  ilim_r, base_r, min_r, max_r;

  // Block state.
  state_t                    state_r, state_nxt;
  logic [SENSORS-1:0]        mask_r;
  logic signed [ERR_W-1:0]   last_err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic                      sticky_r;
  logic [WINDOW_LEN-1:0]     lwin_r, rwin_r;
  logic [HIT_CNT_W-1:0]      lcnt_r, rcnt_r;
  logic signed [ERR_W-1:0]   err_r;
  logic                      lost_r;
  logic signed [CORR_W-1:0]  corr_r;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic signed [ERR_W-1:0]   out_err_r;
  logic signed [CORR_W-1:0]  out_corr_r;
  logic [DUTY_W-1:0]         out_ldut_r, out_rdut_r;
  logic                      out_lbr_r, out_rbr_r, out_lost_r;
  logic [HITS_W-1:0]         out_lhit_r, out_rhit_r;

  logic                      accept;
  logic                      mac_start;
  logic                      load;
  mac_stat_t                 mac_stat;
  logic signed [ACC_W-1:0]   mac_acc;

  // Sensor classification.
  logic [ADC_BITS-1:0] sample [SENSORS];
  logic [10:0]         thr_gap;
  logic [PROD_W-1:0]   thr_prod;
  logic                thr_ok;
  logic [SENSORS-1:0]  mask_in;

  // Set-up step.
  logic                      lost_now;
  logic signed [ERR_W-1:0]   err_now;
  logic signed [DIFF_W-1:0]  diff_now;
  logic signed [SUM_W-1:0]   integ_sum, lim;
  logic signed [INTEG_W-1:0] integ_new;
  logic                      sticky_new;
  logic [WINDOW_LEN-1:0]     lwin_nxt, rwin_nxt;
  logic [HIT_CNT_W-1:0]      lcnt_nxt, rcnt_nxt;

  // Rounding and duty steps.
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [CFULL_W-1:0] corr_full;
  logic [CFULL_W-CORR_W:0]   corr_top;
  logic signed [CORR_W-1:0]  corr_sat;
  logic signed [DSUM_W-1:0]  base_ext, lo_ext, hi_ext, dl_sum, dr_sum;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [DSUM_W-1:0] v,
                                                   input logic signed [DSUM_W-1:0] lo,
                                                   input logic signed [DSUM_W-1:0] hi);
    logic signed [DSUM_W-1:0] t;
    t = v;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return t[DUTY_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      thr_r    <= THR_W'(550);
      ilim_r   <= PCT_W'(60);
      base_r   <= PCT_W'(60);
      min_r    <= PCT_W'(55);
      max_r    <= PCT_W'(68);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:    gain_p_r <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:    gain_i_r <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:    gain_d_r <= cfg_data[GAIN_W-1:0];
        CFG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        CFG_INT_LIMIT: ilim_r   <= cfg_data[PCT_W-1:0];
        CFG_BASE_DUTY: base_r   <= cfg_data[PCT_W-1:0];
        CFG_MIN_DUTY:  min_r    <= cfg_data[PCT_W-1:0];
        CFG_MAX_DUTY:  max_r    <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // A sensor is black when its mapped level exceeds the threshold, which is
  // the same as x*1200 lying below (1000 - threshold) * full scale.
  assign sample[0] = in_sample_far_left;
  assign sample[1] = in_sample_left;
  assign sample[2] = in_sample_center;
  assign sample[3] = in_sample_right;
  assign sample[4] = in_sample_far_right;

  assign thr_ok   = thr_r < THR_W'(MAP_TOP);
  assign thr_gap  = 11'(MAP_TOP) - {1'b0, thr_r};
  assign thr_prod = PROD_W'(thr_gap) * PROD_W'(ADC_MAX);

  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      mask_in[s] = thr_ok && ((PROD_W'(sample[s]) * PROD_W'(MAP_SPAN)) < thr_prod);
    end
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    lost_now = mask_r == '0;
    if (lost_now) begin
      err_now = (last_err_r > 13'sd0) ? LOST_ERROR : -LOST_ERROR;
    end else begin
      err_now = centroid_err(mask_r);
    end
    diff_now  = DIFF_W'(err_now) - DIFF_W'(last_err_r);
    integ_sum = SUM_W'(integ_r) + SUM_W'(err_now);
    lim       = $signed({2'b00, ilim_r, 8'h00});
    if (integ_sum > lim) begin
      integ_new = lim[INTEG_W-1:0];
    end else if (integ_sum < -lim) begin
      integ_new = INTEG_W'(-lim);
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end
    if (mask_r[0]) begin
      sticky_new = 1'b0;
    end else if (mask_r[SENSORS-1]) begin
      sticky_new = 1'b1;
    end else begin
      sticky_new = sticky_r;
    end
    lwin_nxt = WINDOW_LEN'({lwin_r, mask_r[0]});
    rwin_nxt = WINDOW_LEN'({rwin_r, mask_r[SENSORS-1]});
    lcnt_nxt = lcnt_r - HIT_CNT_W'(lwin_r[WINDOW_LEN-1]) + HIT_CNT_W'(mask_r[0]);
    rcnt_nxt = rcnt_r - HIT_CNT_W'(rwin_r[WINDOW_LEN-1]) + HIT_CNT_W'(mask_r[SENSORS-1]);
  end

  lsps_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .gain_p (gain_p_r),
    .gain_i (gain_i_r),
    .gain_d (gain_d_r),
    .err    (err_now),
    .integ  (integ_new),
    .diff   (diff_now),
    .acc    (mac_acc),
    .stat   (mac_stat)
  );

  // Division by 256 truncating toward zero, then saturation to the field.
  always_comb begin
    acc_adj   = mac_acc[ACC_W-1] ? (mac_acc + ACC_W'(255)) : mac_acc;
    corr_full = $signed(acc_adj[ACC_W-1:8]);
    corr_top  = corr_full[CFULL_W-1:CORR_W-1];
    if ((&corr_top) || !(|corr_top)) begin
      corr_sat = corr_full[CORR_W-1:0];
    end else if (corr_full[CFULL_W-1]) begin
      corr_sat = $signed({1'b1, {(CORR_W-1){1'b0}}});
    end else begin
      corr_sat = $signed({1'b0, {(CORR_W-1){1'b1}}});
    end
  end

  always_comb begin
    base_ext = DSUM_W'({base_r, 8'h00});
    lo_ext   = DSUM_W'({min_r, 8'h00});
    hi_ext   = DSUM_W'({max_r, 8'h00});
    dl_sum   = base_ext + DSUM_W'(corr_r);
    dr_sum   = base_ext - DSUM_W'(corr_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  if (mac_stat.done && !mac_stat.busy) state_nxt = ST_CORR;
      ST_CORR: state_nxt = ST_OUT;
      ST_OUT:  if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = state_r != ST_IDLE;
    mac_start     = state_r == ST_PREP;
    load          = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      integ_r     <= '0;
      sticky_r    <= 1'b0;
      lwin_r      <= '0;
      rwin_r      <= '0;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_PREP) begin
        last_err_r <= err_now;
        integ_r    <= integ_new;
        sticky_r   <= sticky_new;
        lwin_r     <= lwin_nxt;
        rwin_r     <= rwin_nxt;
        lcnt_r     <= lcnt_nxt;
        rcnt_r     <= rcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask_r <= mask_in;
    end
    if (state_r == ST_PREP) begin
      err_r  <= err_now;
      lost_r <= lost_now;
    end
    if (state_r == ST_CORR) begin
      corr_r <= corr_sat;
    end
    if (load) begin
      out_err_r  <= err_r;
      out_corr_r <= corr_r;
      out_ldut_r <= clamp_duty(dl_sum, lo_ext, hi_ext);
      out_rdut_r <= clamp_duty(dr_sum, lo_ext, hi_ext);
      out_lbr_r  <= mask_r[0];
      out_rbr_r  <= sticky_r;
      out_lost_r <= lost_r;
      out_lhit_r <= lcnt_r[HITS_W-1:0];
      out_rhit_r <= rcnt_r[HITS_W-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_position_error   = out_err_r;
  assign out_steer_correction = out_corr_r;
  assign out_left_duty_out    = out_ldut_r;
  assign out_right_duty_out   = out_rdut_r;
  assign out_left_branch      = out_lbr_r;
  assign out_right_branch     = out_rbr_r;
  assign out_line_lost        = out_lost_r;
  assign out_left_hits        = out_lhit_r;
  assign out_right_hits       = out_rhit_r;

endmodule
`default_nettype wire

// ----- rtl/lsps_checker.sv -----
`default_nettype none
// Port-level checks of the line sensor steering block, bound to its top level.
`include "line_sensor_pid_steering_macros.svh"
module lsps_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [lsps_pkg::ERR_W-1:0]  out_position_error,
  input logic signed [lsps_pkg::CORR_W-1:0] out_steer_correction,
  input logic                               out_left_branch,
  input logic                               out_right_branch,
  input logic                               out_line_lost
);

  `LSPS_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
  `LSPS_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_steer_correction))
  `LSPS_ASSERT_NOW(a_lost_error, out_valid && out_line_lost, out_position_error == 13'sd2560 || out_position_error == -13'sd2560)
  `LSPS_ASSERT_NOW(a_centroid_range, out_valid && !out_line_lost, out_position_error >= -13'sd1280 && out_position_error <= 13'sd1280)
  `LSPS_ASSERT_NOW(a_branch_exclusive, out_valid && out_left_branch, !out_right_branch)

endmodule

bind line_sensor_pid_steering lsps_checker u_lsps_checker (.*);
`default_nettype wire

// ----- tb/line_sensor_pid_steering_tb.sv -----
// Self-checking testbench for the line sensor PID steering block, with a frame predictor.
`timescale 1ns / 100ps
`default_nettype none

module line_sensor_pid_steering_tb;
  import lsps_pkg::*;

  localparam int ADC_TOP      = 4095;
  localparam int LEVEL_TOP    = 1000;
  localparam int LEVEL_SPAN   = 1200;
  localparam int LOST_LEVEL   = 2560;
  localparam int HIT_SPAN     = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 12;
  localparam int CYCLE_LIMIT  = 250000;
  localparam longint CORR_TOP = 64'sd8388607;
  localparam longint CORR_BOT = -64'sd8388608;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd11;
  localparam int SENSOR_WEIGHT [SENSORS] = '{-5, -3, 1, 3, 5};

  typedef logic [SENSORS-1:0][ADC_BITS_DEF-1:0] frame_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  position_error;
    logic signed [CORR_W-1:0] steer_correction;
    logic [DUTY_W-1:0]        duty_lhs;
    logic [DUTY_W-1:0]        duty_rhs;
    logic                     left_branch;
    logic                     right_branch;
    logic                     line_lost;
    logic [HITS_W-1:0]        left_hits;
    logic [HITS_W-1:0]        right_hits;
  } steer_t;

  typedef struct {
    bit [15:0] gain_p;
    bit [15:0] gain_i;
    bit [15:0] gain_d;
    bit [9:0]  black_level;
    bit [6:0]  integ_limit;
    bit [6:0]  base_pct;
    bit [6:0]  min_pct;
    bit [6:0]  max_pct;
  } settings_t;

  class steering_tracker;
    bit [15:0] gain_p, gain_i, gain_d;
    bit [9:0]  black_level;
    bit [6:0]  integ_limit, base_pct, min_pct, max_pct;
    int        last_err, integ;
    bit        right_hold;
    bit [HIT_SPAN-1:0] left_win, right_win;
    int        win_pos, left_cnt, right_cnt;
    steer_t    pending_steer[$];
    int        errors;

    function new();
      gain_p = 0; gain_i = 0; gain_d = 0;
      black_level = 550; integ_limit = 60;
      base_pct = 60; min_pct = 55; max_pct = 68;
      last_err = 0; integ = 0; right_hold = 0;
      left_win = '0; right_win = '0;
      win_pos = 0; left_cnt = 0; right_cnt = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_P:    gain_p = data;
        CFG_GAIN_I:    gain_i = data;
        CFG_GAIN_D:    gain_d = data;
        CFG_THRESHOLD: black_level = data[9:0];
        CFG_INT_LIMIT: integ_limit = data[6:0];
        CFG_BASE_DUTY: base_pct = data[6:0];
        CFG_MIN_DUTY:  min_pct = data[6:0];
        CFG_MAX_DUTY:  max_pct = data[6:0];
        default: ;
      endcase
    endfunction

    function bit is_black(logic [ADC_BITS_DEF-1:0] x);
      return (LEVEL_TOP - (int'(x) * LEVEL_SPAN) / ADC_TOP) > int'(black_level);
    endfunction

    function longint clamp_pct(longint v);
      longint lo, hi;
      lo = longint'(min_pct) * 256;
      hi = longint'(max_pct) * 256;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    function void take_frame(frame_t f);
      steer_t e;
      bit [SENSORS-1:0] blk;
      int wsum, nblk, err, diff, lim, s;
      longint acc, corr;
      wsum = 0;
      nblk = 0;
      for (s = 0; s < SENSORS; s++) begin
        blk[s] = is_black(f[s]);
        if (blk[s]) begin
          wsum += SENSOR_WEIGHT[s];
          nblk++;
        end
      end
      if (nblk != 0) err = (wsum * 256) / nblk;
      else err = (last_err > 0) ? LOST_LEVEL : -LOST_LEVEL;
      if (blk[0]) right_hold = 1'b0;
      else if (blk[SENSORS-1]) right_hold = 1'b1;
      diff = err - last_err;
      lim = int'(integ_limit) * 256;
      integ += err;
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      acc = longint'(gain_p) * err + longint'(gain_i) * integ + longint'(gain_d) * diff;
      corr = acc / 256;
      if (corr > CORR_TOP) corr = CORR_TOP;
      if (corr < CORR_BOT) corr = CORR_BOT;
      last_err = err;
      left_cnt = left_cnt - int'(left_win[win_pos]) + int'(blk[0]);
      right_cnt = right_cnt - int'(right_win[win_pos]) + int'(blk[SENSORS-1]);
      left_win[win_pos] = blk[0];
      right_win[win_pos] = blk[SENSORS-1];
      win_pos = (win_pos + 1) % HIT_SPAN;
      e.position_error = ERR_W'(err);
      e.steer_correction = CORR_W'(corr);
      e.duty_lhs = DUTY_W'(clamp_pct(longint'(base_pct) * 256 + corr));
      e.duty_rhs = DUTY_W'(clamp_pct(longint'(base_pct) * 256 - corr));
      e.left_branch = blk[0];
      e.right_branch = right_hold;
      e.line_lost = (nblk == 0);
      e.left_hits = HITS_W'(left_cnt);
      e.right_hits = HITS_W'(right_cnt);
      pending_steer.push_back(e);
    endfunction

    function void match_field(string name, logic signed [63:0] want,
                              logic signed [63:0] seen);
      if (want !== seen) begin
        $error("%s expected %0d got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_steer(steer_t got);
      steer_t e;
      if (pending_steer.size() == 0) begin
        $error("result with no request waiting");
        errors++;
        return;
      end
      e = pending_steer.pop_front();
      match_field("position_error", e.position_error, got.position_error);
      match_field("steer_correction", e.steer_correction, got.steer_correction);
      match_field("left_duty_out", {1'b0, e.duty_lhs}, {1'b0, got.duty_lhs});
      match_field("right_duty_out", {1'b0, e.duty_rhs}, {1'b0, got.duty_rhs});
      match_field("left_branch", {1'b0, e.left_branch}, {1'b0, got.left_branch});
      match_field("right_branch", {1'b0, e.right_branch}, {1'b0, got.right_branch});
      match_field("line_lost", {1'b0, e.line_lost}, {1'b0, got.line_lost});
      match_field("left_hits", {1'b0, e.left_hits}, {1'b0, got.left_hits});
      match_field("right_hits", {1'b0, e.right_hits}, {1'b0, got.right_hits});
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ADC_BITS_DEF-1:0] in_sample_far_left = '0;
  logic [ADC_BITS_DEF-1:0] in_sample_left = '0;
  logic [ADC_BITS_DEF-1:0] in_sample_center = '0;
  logic [ADC_BITS_DEF-1:0] in_sample_right = '0;
  logic [ADC_BITS_DEF-1:0] in_sample_far_right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ERR_W-1:0]  out_position_error;
  logic signed [CORR_W-1:0] out_steer_correction;
  logic [DUTY_W-1:0] out_left_duty_out;
  logic [DUTY_W-1:0] out_right_duty_out;
  logic out_left_branch;
  logic out_right_branch;
  logic out_line_lost;
  logic [HITS_W-1:0] out_left_hits;
  logic [HITS_W-1:0] out_right_hits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  steering_tracker tracker = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  line_sensor_pid_steering uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_far_left  (in_sample_far_left),
    .in_sample_left      (in_sample_left),
    .in_sample_center    (in_sample_center),
    .in_sample_right     (in_sample_right),
    .in_sample_far_right (in_sample_far_right),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_position_error  (out_position_error),
    .out_steer_correction(out_steer_correction),
    .out_left_duty_out   (out_left_duty_out),
    .out_right_duty_out  (out_right_duty_out),
    .out_left_branch     (out_left_branch),
    .out_right_branch    (out_right_branch),
    .out_line_lost       (out_line_lost),
    .out_left_hits       (out_left_hits),
    .out_right_hits      (out_right_hits),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_steer('{out_position_error, out_steer_correction, out_left_duty_out,
                            out_right_duty_out, out_left_branch, out_right_branch,
                            out_line_lost, out_left_hits, out_right_hits});
    end
  end

  always @(posedge clk) begin
    if (hold_ticket != hold_served) begin
      hold_served = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [ADC_BITS_DEF-1:0] pick_sample(bit want_black, int style);
    int k, edge_x;
    k = LEVEL_TOP - int'(tracker.black_level);
    if (k <= 0) return ADC_BITS_DEF'($urandom_range(0, ADC_TOP));
    edge_x = (k * ADC_TOP - 1) / LEVEL_SPAN;
    if (want_black) begin
      case (style)
        0:       return '0;
        1:       return ADC_BITS_DEF'($urandom_range(0, edge_x));
        default: return ADC_BITS_DEF'(edge_x);
      endcase
    end
    case (style)
      0:       return ADC_BITS_DEF'(ADC_TOP);
      1:       return ADC_BITS_DEF'($urandom_range(edge_x + 1, ADC_TOP));
      default: return ADC_BITS_DEF'(edge_x + 1);
    endcase
  endfunction

  function automatic frame_t frame_of(bit [SENSORS-1:0] black_mask, int style);
    frame_t f;
    int s;
    for (s = 0; s < SENSORS; s++) f[s] = pick_sample(black_mask[s], style);
    return f;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    bit [SENSORS-1:0] m;
    int r, start, len, s;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      for (s = 0; s < SENSORS; s++) f[s] = ADC_BITS_DEF'($urandom_range(0, ADC_TOP));
      return f;
    end
    m = '0;
    if (r < 60) begin
      start = $urandom_range(0, SENSORS - 1);
      len = $urandom_range(1, 3);
      for (s = start; s < start + len && s < SENSORS; s++) m[s] = 1'b1;
    end else if (r >= 70) begin
      m = SENSORS'($urandom_range(0, (1 << SENSORS) - 1));
    end
    return frame_of(m, ($urandom_range(0, 9) == 0) ? 2 : 1);
  endfunction

  function automatic bit [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    s.gain_p = pick_gain();
    s.gain_i = pick_gain();
    s.gain_d = pick_gain();
    s.black_level = 10'($urandom_range(150, 950));
    s.integ_limit = 7'($urandom_range(0, 127));
    s.base_pct = 7'($urandom_range(0, 100));
    s.min_pct = 7'($urandom_range(0, 60));
    s.max_pct = 7'($urandom_range(40, 100));
    return s;
  endfunction

  task automatic send_frame(frame_t f);
    in_valid <= 1'b1;
    in_sample_far_left <= f[0];
    in_sample_left <= f[1];
    in_sample_center <= f[2];
    in_sample_right <= f[3];
    in_sample_far_right <= f[4];
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_frame(f);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_reg(idx, data);
  endtask

  task automatic apply_settings(settings_t s);
    write_reg(CFG_GAIN_P, s.gain_p);
    write_reg(CFG_GAIN_I, s.gain_i);
    write_reg(CFG_GAIN_D, s.gain_d);
    write_reg(CFG_THRESHOLD, 16'(s.black_level));
    write_reg(CFG_INT_LIMIT, 16'(s.integ_limit));
    write_reg(CFG_BASE_DUTY, 16'(s.base_pct));
    write_reg(CFG_MIN_DUTY, 16'(s.min_pct));
    write_reg(CFG_MAX_DUTY, 16'(s.max_pct));
    cfg_valid <= 1'b0;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (tracker.pending_steer.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    static bit [SENSORS-1:0] dir_masks [22] = '{
      5'b00000, 5'b10000, 5'b00000, 5'b00001, 5'b00000, 5'b00100, 5'b11111, 5'b00011,
      5'b00110, 5'b01100, 5'b11000, 5'b00010, 5'b01000, 5'b10001, 5'b00111, 5'b11100,
      5'b01110, 5'b01011, 5'b11110, 5'b10000, 5'b00001, 5'b11101};
    static int dir_styles [22] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                   0, 2, 2, 2, 2, 1};
    settings_t s;
    int ph, n, items;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_masks[i]) send_frame(frame_of(dir_masks[i], dir_styles[i]));

    for (ph = 0; ph < 10; ph++) begin
      settle_block();
      case (ph)
        0: s = '{16'd256, 16'd32, 16'd128, 10'd550, 7'd60, 7'd60, 7'd55, 7'd68};
        1: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0, 7'd127, 7'd100, 7'd0, 7'd100};
        2: s = '{16'd4096, 16'd0, 16'hFFFF, 10'd1023, 7'd0, 7'd0, 7'd100, 7'd0};
        3: s = '{16'd0, 16'hFFFF, 16'd0, 10'd1000, 7'd127, 7'd0, 7'd0, 7'd0};
        default: s = random_settings();
      endcase
      if (ph == 2) write_reg(CFG_SPARE, 16'hFFFF);
      apply_settings(s);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 45; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 45; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      items = (ph == 2 || ph == 3) ? 40 : 120;
      for (n = 0; n < items; n++) begin
        if (n == 40 && (ph == 1 || ph == 6)) hold_ticket++;
        send_frame(random_frame());
        if ($urandom_range(0, 99) < send_idle_pct) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end

    settle_block();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_steer.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/lsps_pkg.sv
rtl/lsps_mac.sv
rtl/line_sensor_pid_steering.sv
rtl/lsps_checker.sv
tb/line_sensor_pid_steering_tb.sv
